// ----- design/page_framebuffer_draw_and_refresh_unit_assert.svh -----
// Assertion macros used by the page framebuffer datapath.
`ifndef PAGE_FRAMEBUFFER_DRAW_AND_REFRESH_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_AND_REFRESH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PFB_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pfb_pkg.sv -----
// Types, codes and constants shared by the page framebuffer modules.
`default_nettype none

package pfb_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;
    localparam int GROUP_WIDTH = 32;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    localparam logic [2:0] KIND_POINT   = 3'd0;
    localparam logic [2:0] KIND_FILL    = 3'd1;
    localparam logic [2:0] KIND_CLEAR   = 3'd2;
    localparam logic [2:0] KIND_OVERLAY = 3'd3;
    localparam logic [2:0] KIND_REFRESH = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic       pixel_on;
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] overlay_byte;
        logic [1:0] column_group;
    } in_item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] payload;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_PAGE,
        EMIT_LOW,
        EMIT_HIGH,
        EMIT_DATA
    } emit_t;

    typedef struct packed {
        logic  load;
        logic  init;
        logic  clr_frame;
        logic  clr_ovl;
        logic  clr_step;
        logic  fill_wr;
        logic  ovl_wr;
        logic  advance;
        emit_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       fill_empty;
        logic       fill_last;
        logic       ref_none;
        logic       grp_zero;
        logic       ref_last;
        logic       ovl_ok;
        logic       clr_last;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/page_framebuffer_draw_and_refresh_unit.sv -----
// Top level of the page framebuffer draw and refresh unit.
//
//   Channel   Ports                       Direction  Contents
//   s_        s_valid s_ready s_data      in         one draw/fill/clear/overlay/refresh request
//   m_        m_valid m_ready m_data      out        one panel byte (command or data) per transaction
//
// One request is worked at a time; the single-port read/write frame store sets the pace.
// Point and fill read and rewrite each touched column byte; clear sweeps the whole frame store.
// Overlay writes one byte. Refresh sends up to 32 column bytes, after three command bytes for group 0.
// After reset a sweep over all PAGES*COLUMNS bytes zeroes both stores; s_ready stays low meanwhile.
// A stalled m_ready holds the output register and the refresh walk; s_ready rises once the
// last byte sits in the output register.
`default_nettype none

module page_framebuffer_draw_and_refresh_unit
    import pfb_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    pfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    pfb_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- design/pfb_datapath.sv -----
// Datapath: frame and overlay stores, cursors, masks and the output register.
`default_nettype none

`include "page_framebuffer_draw_and_refresh_unit_assert.svh"

module pfb_datapath
    import pfb_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire in_item_t   s_data,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      st,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = PAGES * 8;
    localparam logic [7:0] COL_MAX = 8'(COLUMNS - 1);
    localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);

    function automatic logic [AW-1:0] byte_addr(input logic [4:0] p, input logic [8:0] c);
        logic [13:0] full;
        full = 14'(p) * 14'(COLUMNS) + 14'(c);
        return full[AW-1:0];
    endfunction

    function automatic logic [7:0] band_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        logic [2:0] r;
        for (int i = 0; i < 8; i++) begin
            r    = 3'(7 - i);
            m[i] = (r >= lo) && (r <= hi);
        end
        return m;
    endfunction

    in_item_t        item_reg;
    logic [7:0]      x_reg;
    logic [3:0]      band_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [7:0]      frame_q_reg;
    logic [7:0]      ovl_q_reg;
    logic            m_valid_reg;
    out_item_t       m_data_reg;

    logic [7:0] frame_mem [DEPTH];
    logic [7:0] ovl_mem   [DEPTH];

    in_item_t      item_load;
    logic [7:0]    xe_c;
    logic [7:0]    ye_c;
    logic [8:0]    ref_first;
    logic [8:0]    ref_sum;
    logic [8:0]    ref_stop;
    logic [2:0]    mask_lo;
    logic [2:0]    mask_hi;
    logic [7:0]    mask;
    logic [7:0]    merged;
    logic [AW-1:0] fill_addr;
    logic [AW-1:0] ref_addr;
    logic [AW-1:0] ovl_addr;
    logic [AW-1:0] cur_addr;
    logic          frame_we;
    logic [7:0]    frame_wd;
    logic          ovl_we;
    logic [7:0]    ovl_wd;
    out_item_t     out_next;

    assign xe_c      = (item_reg.x_end > COL_MAX) ? COL_MAX : item_reg.x_end;
    assign ye_c      = (item_reg.y_end > ROW_MAX) ? ROW_MAX : item_reg.y_end;
    assign ref_first = 9'(item_reg.column_group) * 9'(GROUP_WIDTH);
    assign ref_sum   = ref_first + 9'(GROUP_WIDTH - 1);
    assign ref_stop  = (ref_sum > 9'(COLUMNS - 1)) ? 9'(COLUMNS - 1) : ref_sum;

    assign mask_lo = (band_reg == item_reg.y_start[6:3]) ? item_reg.y_start[2:0] : 3'd0;
    assign mask_hi = (band_reg == ye_c[6:3]) ? ye_c[2:0] : 3'd7;
    assign mask    = band_mask(mask_lo, mask_hi);
    assign merged  = frame_q_reg | ovl_q_reg;

    assign fill_addr = byte_addr(5'(PAGES - 1) - 5'(band_reg), {1'b0, x_reg});
    assign ref_addr  = byte_addr(5'(item_reg.page), {1'b0, x_reg});
    assign ovl_addr  = byte_addr(5'(item_reg.page), 9'(item_reg.column));

    // A point is a one-by-one rectangle.
    always_comb begin
        item_load = s_data;
        if (s_data.kind == KIND_POINT) begin
            item_load.x_end = s_data.x_start;
            item_load.y_end = s_data.y_start;
        end
    end

    always_comb begin
        priority if (cmd.clr_frame || cmd.clr_ovl) begin
            cur_addr = clr_cnt_reg;
        end else if (cmd.ovl_wr) begin
            cur_addr = ovl_addr;
        end else if (item_reg.kind == KIND_REFRESH) begin
            cur_addr = ref_addr;
        end else begin
            cur_addr = fill_addr;
        end
    end

    always_comb begin
        frame_we = cmd.clr_frame || cmd.fill_wr || (cmd.emit == EMIT_DATA);
        priority if (cmd.clr_frame) begin
            frame_wd = 8'd0;
        end else if (cmd.fill_wr) begin
            frame_wd = item_reg.pixel_on ? (frame_q_reg | mask) : (frame_q_reg & ~mask);
        end else begin
            frame_wd = merged;
        end
        ovl_we = cmd.clr_ovl || cmd.ovl_wr;
        ovl_wd = cmd.clr_ovl ? 8'd0 : item_reg.overlay_byte;
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[cur_addr] <= frame_wd;
        end
        frame_q_reg <= frame_mem[cur_addr];
    end

    always_ff @(posedge aclk) begin
        if (ovl_we) begin
            ovl_mem[cur_addr] <= ovl_wd;
        end
        ovl_q_reg <= ovl_mem[cur_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= item_load;
        end
        if (cmd.init) begin
            x_reg    <= (item_reg.kind == KIND_REFRESH) ? ref_first[7:0] : item_reg.x_start;
            band_reg <= item_reg.y_start[6:3];
        end else if (cmd.advance) begin
            if (item_reg.kind == KIND_REFRESH) begin
                x_reg <= x_reg + 8'd1;
            end else if (x_reg == xe_c) begin
                x_reg    <= item_reg.x_start;
                band_reg <= band_reg + 4'd1;
            end else begin
                x_reg <= x_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= st.clr_last ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    always_comb begin
        unique case (cmd.emit)
            EMIT_PAGE: out_next = '{is_data: 1'b0, payload: CMD_PAGE_BASE + 8'(item_reg.page),
                                    last: 1'b0};
            EMIT_LOW:  out_next = '{is_data: 1'b0, payload: CMD_COL_LOW, last: 1'b0};
            EMIT_HIGH: out_next = '{is_data: 1'b0, payload: CMD_COL_HIGH, last: 1'b0};
            EMIT_DATA: out_next = '{is_data: 1'b1, payload: merged, last: st.ref_last};
            default:   out_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit != EMIT_NONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit != EMIT_NONE) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        st.kind       = item_reg.kind;
        st.fill_empty = (item_reg.x_start > xe_c) || (item_reg.y_start > ye_c);
        st.fill_last  = (x_reg == xe_c) && (band_reg == ye_c[6:3]);
        st.ref_none   = (5'(item_reg.page) >= 5'(PAGES)) || (ref_first >= 9'(COLUMNS));
        st.grp_zero   = (item_reg.column_group == 2'd0);
        st.ref_last   = ({1'b0, x_reg} == ref_stop);
        st.ovl_ok     = (5'(item_reg.page) < 5'(PAGES)) && (9'(item_reg.column) < 9'(COLUMNS));
        st.clr_last   = (clr_cnt_reg == AW'(DEPTH - 1));
        st.out_free   = !m_valid_reg || m_ready;
    end

    `PFB_ASSERT_IMPL(a_emit_free, aclk, aresetn, cmd.emit != EMIT_NONE, st.out_free, "emit into a busy output register")
    `PFB_ASSERT_IMPL(a_last_data, aclk, aresetn, m_valid_reg && m_data_reg.last, m_data_reg.is_data, "last flag on a command byte")
    `PFB_ASSERT_NEXT(a_clr_wrap, aclk, aresetn, cmd.clr_step && st.clr_last, clr_cnt_reg == '0, "clear sweep did not wrap")

endmodule

`default_nettype wire

// ----- design/pfb_ctrl.sv -----
// Controller: sequences clear sweeps, fills, overlay writes and refresh groups.
`default_nettype none

module pfb_ctrl
    import pfb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_CLR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_OVL_WR,
        ST_CMD_PAGE,
        ST_CMD_LOW,
        ST_CMD_HIGH,
        ST_REF_RD,
        ST_REF_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        unique case (state_reg)
            ST_RST_CLR: begin
                cmd.clr_frame = 1'b1;
                cmd.clr_ovl   = 1'b1;
                cmd.clr_step  = 1'b1;
                if (st.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.init = 1'b1;
                unique case (st.kind)
                    KIND_POINT, KIND_FILL: begin
                        state_next = st.fill_empty ? ST_IDLE : ST_FILL_RD;
                    end
                    KIND_CLEAR:   state_next = ST_CLR;
                    KIND_OVERLAY: state_next = st.ovl_ok ? ST_OVL_WR : ST_IDLE;
                    KIND_REFRESH: begin
                        priority if (st.ref_none) begin
                            state_next = ST_IDLE;
                        end else if (st.grp_zero) begin
                            state_next = ST_CMD_PAGE;
                        end else begin
                            state_next = ST_REF_RD;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_CLR: begin
                cmd.clr_frame = 1'b1;
                cmd.clr_step  = 1'b1;
                if (st.clr_last) state_next = ST_IDLE;
            end
            ST_FILL_RD: state_next = ST_FILL_WR;
            ST_FILL_WR: begin
                cmd.fill_wr = 1'b1;
                cmd.advance = 1'b1;
                state_next  = st.fill_last ? ST_IDLE : ST_FILL_RD;
            end
            ST_OVL_WR: begin
                cmd.ovl_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CMD_PAGE: begin
                if (st.out_free) begin
                    cmd.emit   = EMIT_PAGE;
                    state_next = ST_CMD_LOW;
                end
            end
            ST_CMD_LOW: begin
                if (st.out_free) begin
                    cmd.emit   = EMIT_LOW;
                    state_next = ST_CMD_HIGH;
                end
            end
            ST_CMD_HIGH: begin
                if (st.out_free) begin
                    cmd.emit   = EMIT_HIGH;
                    state_next = ST_REF_RD;
                end
            end
            ST_REF_RD: state_next = ST_REF_WR;
            ST_REF_WR: begin
                if (st.out_free) begin
                    cmd.emit    = EMIT_DATA;
                    cmd.advance = 1'b1;
                    state_next  = st.ref_last ? ST_IDLE : ST_REF_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RST_CLR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

// ----- tb/page_framebuffer_draw_and_refresh_unit_test.sv -----
// Self-checking testbench for the page framebuffer draw and refresh unit.
`default_nettype none

module page_framebuffer_draw_and_refresh_unit_test;
    import pfb_pkg::*;

    localparam int ROWS        = PAGES_DEF * 8;
    localparam int STORE_BYTES = PAGES_DEF * COLUMNS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 200;
    localparam int RANDOM_REQS = 400;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        in_item_t   req;
        bit         typed;
        int         n_data;
        logic [7:0] data_byte;
    } table_row_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic [7:0] frame_img   [STORE_BYTES];
    logic [7:0] overlay_img [STORE_BYTES];
    out_item_t  refresh_bytes[$];
    out_item_t  pending_bytes[$];
    table_row_t directed_rows[$];

    int errors         = 0;
    int cycles         = 0;
    int burst_left     = 0;
    int reqs_accepted  = 0;
    int refresh_reqs   = 0;
    int bytes_checked  = 0;

    page_framebuffer_draw_and_refresh_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void plot_pixel(input int x, input int y, input logic on);
        int idx;
        logic [7:0] mask;
        if (x >= COLUMNS_DEF || y >= ROWS)
            return;
        idx  = (PAGES_DEF - 1 - y / 8) * COLUMNS_DEF + x;
        mask = 8'h80 >> (y % 8);
        frame_img[idx] = on ? (frame_img[idx] | mask) : (frame_img[idx] & ~mask);
    endfunction

    function automatic void push_byte(input logic is_data, input logic [7:0] val);
        out_item_t b;
        b.is_data = is_data;
        b.payload = val;
        b.last    = 1'b0;
        refresh_bytes.push_back(b);
    endfunction

    function automatic void mark_last();
        out_item_t b;
        if (refresh_bytes.size() == 0)
            return;
        b = refresh_bytes.pop_back();
        b.last = 1'b1;
        refresh_bytes.push_back(b);
    endfunction

    // Applies one request to the shadow stores and builds the panel bytes it causes.
    function automatic void frame_update(input in_item_t r);
        int xe, ye, first, stop, idx;
        refresh_bytes.delete();
        case (r.kind)
            KIND_POINT: plot_pixel(r.x_start, r.y_start, r.pixel_on);
            KIND_FILL: begin
                if (r.x_start <= r.x_end && r.y_start <= r.y_end) begin
                    xe = (r.x_end > COLUMNS_DEF - 1) ? COLUMNS_DEF - 1 : r.x_end;
                    ye = (r.y_end > ROWS - 1) ? ROWS - 1 : r.y_end;
                    for (int x = r.x_start; x <= xe; x++)
                        for (int y = r.y_start; y <= ye; y++)
                            plot_pixel(x, y, r.pixel_on);
                end
            end
            KIND_CLEAR: begin
                foreach (frame_img[i])
                    frame_img[i] = 8'h00;
            end
            KIND_OVERLAY: begin
                if (r.page < PAGES_DEF && r.column < COLUMNS_DEF)
                    overlay_img[r.page * COLUMNS_DEF + r.column] = r.overlay_byte;
            end
            KIND_REFRESH: begin
                if (r.page < PAGES_DEF) begin
                    first = r.column_group * GROUP_WIDTH;
                    stop  = first + GROUP_WIDTH;
                    if (stop > COLUMNS_DEF)
                        stop = COLUMNS_DEF;
                    if (r.column_group == 2'd0) begin
                        push_byte(1'b0, CMD_PAGE_BASE + r.page);
                        push_byte(1'b0, CMD_COL_LOW);
                        push_byte(1'b0, CMD_COL_HIGH);
                    end
                    for (int c = first; c < stop; c++) begin
                        idx = r.page * COLUMNS_DEF + c;
                        frame_img[idx] = frame_img[idx] | overlay_img[idx];
                        push_byte(1'b1, frame_img[idx]);
                    end
                    mark_last();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic in_item_t req(input logic [2:0] kind, input logic [7:0] xs,
                                     input logic [7:0] ys, input logic [7:0] xe,
                                     input logic [7:0] ye, input logic on,
                                     input logic [2:0] pg, input logic [6:0] col,
                                     input logic [7:0] ob, input logic [1:0] grp);
        in_item_t r;
        r.kind         = kind;
        r.x_start      = xs;
        r.y_start      = ys;
        r.x_end        = xe;
        r.y_end        = ye;
        r.pixel_on     = on;
        r.page         = pg;
        r.column       = col;
        r.overlay_byte = ob;
        r.column_group = grp;
        return r;
    endfunction

    function automatic void row(input in_item_t r, input bit typed = 1'b0,
                                input int n_data = 0, input logic [7:0] data_byte = 8'h00);
        table_row_t t;
        t.req       = r;
        t.typed     = typed;
        t.n_data    = n_data;
        t.data_byte = data_byte;
        directed_rows.push_back(t);
    endfunction

    function automatic void build_directed();
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 32, 8'h00);
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 7, 0, 0, 3), 1, 32, 8'h00);
        row(req(KIND_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
        row(req(KIND_SPARE_HI, 255, 255, 255, 255, 1, 7, 127, 255, 3), 1, 0);
        row(req(KIND_POINT, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        row(req(KIND_POINT, 127, 63, 0, 0, 1, 0, 0, 0, 0));
        row(req(KIND_POINT, 128, 0, 0, 0, 1, 0, 0, 0, 0));
        row(req(KIND_POINT, 255, 255, 0, 0, 1, 0, 0, 0, 0));
        row(req(KIND_POINT, 0, 64, 0, 0, 1, 0, 0, 0, 0));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 7, 0, 0, 0));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 3));
        row(req(KIND_FILL, 0, 0, 255, 255, 1, 0, 0, 0, 0));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 3, 0, 0, 1), 1, 32, 8'hFF);
        row(req(KIND_FILL, 10, 0, 5, 63, 0, 0, 0, 0, 0));
        row(req(KIND_FILL, 0, 10, 127, 9, 0, 0, 0, 0, 0));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 2, 0, 0, 2), 1, 32, 8'hFF);
        row(req(KIND_FILL, 3, 3, 3, 3, 0, 0, 0, 0, 0));
        row(req(KIND_FILL, 0, 60, 200, 63, 0, 0, 0, 0, 0));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        row(req(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 5, 0, 0, 2), 1, 32, 8'h00);
        row(req(KIND_OVERLAY, 0, 0, 0, 0, 0, 7, 127, 8'hFF, 0));
        row(req(KIND_OVERLAY, 0, 0, 0, 0, 0, 0, 0, 8'hA5, 0));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 7, 0, 0, 3));
        row(req(KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endfunction

    function automatic in_item_t random_req();
        in_item_t r;
        logic [63:0] junk;
        int roll;
        junk = {$urandom(), $urandom()};
        r    = junk[$bits(in_item_t)-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            r.kind     = KIND_POINT;
            r.x_start  = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 127));
            r.y_start  = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 63));
            r.pixel_on = ($urandom_range(0, 9) < 7);
        end else if (roll < 45) begin
            r.kind = KIND_FILL;
            case ($urandom_range(0, 9))
                0: ;
                1: begin
                    r.x_start = 8'($urandom_range(1, 255));
                    r.x_end   = r.x_start - 8'($urandom_range(1, r.x_start));
                end
                default: begin
                    r.x_start = 8'($urandom_range(0, 135));
                    r.x_end   = r.x_start + 8'($urandom_range(0, 15));
                    r.y_start = 8'($urandom_range(0, 70));
                    r.y_end   = r.y_start + 8'($urandom_range(0, 12));
                end
            endcase
        end else if (roll < 48) begin
            r.kind = KIND_CLEAR;
        end else if (roll < 68) begin
            r.kind = KIND_OVERLAY;
        end else if (roll < 97) begin
            r.kind = KIND_REFRESH;
        end else begin
            r.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        end
        return r;
    endfunction

    task automatic send_req(input in_item_t r, input bit typed, input int n_data,
                            input logic [7:0] data_byte);
        int gap;
        begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 12);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            s_valid <= 1'b1;
            s_data  <= r;
            do @(posedge aclk); while (!s_ready);
            burst_left--;
            reqs_accepted++;
            if (r.kind == KIND_REFRESH)
                refresh_reqs++;
            frame_update(r);
            if (typed) begin
                refresh_bytes.delete();
                if (r.kind == KIND_REFRESH && r.column_group == 2'd0) begin
                    push_byte(1'b0, CMD_PAGE_BASE + r.page);
                    push_byte(1'b0, CMD_COL_LOW);
                    push_byte(1'b0, CMD_COL_HIGH);
                end
                for (int i = 0; i < n_data; i++)
                    push_byte(1'b1, data_byte);
                mark_last();
            end
            foreach (refresh_bytes[i])
                pending_bytes.push_back(refresh_bytes[i]);
        end
    endtask

    initial begin
        foreach (frame_img[i]) begin
            frame_img[i]   = 8'h00;
            overlay_img[i] = 8'h00;
        end
        build_directed();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].typed,
                     directed_rows[i].n_data, directed_rows[i].data_byte);
        repeat (RANDOM_REQS)
            send_req(random_req(), 1'b0, 0, 8'h00);
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d requests (%0d refreshes) incl. clipped points, empty fills,",
                 reqs_accepted, refresh_reqs);
        $display("clears, overlay merges and spare kinds; %0d panel bytes checked",
                 bytes_checked);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Receiver stall pattern: always ready, mostly ready, mostly stalled, periodic.
    always @(posedge aclk) begin
        case ((cycles / 256) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (cycles % 8 < 5);
        endcase
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected panel byte: is_data %0b payload %02h last %0b",
                       m_data.is_data, m_data.payload, m_data.last);
                errors++;
            end else begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (m_data.is_data !== want.is_data) begin
                    $error("is_data: expected %0b, got %0b", want.is_data, m_data.is_data);
                    errors++;
                end
                if (m_data.payload !== want.payload) begin
                    $error("payload: expected %02h, got %02h", want.payload, m_data.payload);
                    errors++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_data.last);
                    errors++;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/pfb_pkg.sv
design/pfb_datapath.sv
design/pfb_ctrl.sv
design/page_framebuffer_draw_and_refresh_unit.sv
tb/page_framebuffer_draw_and_refresh_unit_test.sv
